// ===== src/lfc_pkg.sv =====
// shared types, constants and the crc-16 byte update for the link frame checker
// no dependencies
package lfc_pkg;

  // frame layout and protocol constants
  localparam int unsigned DEF_PAYLOAD_BYTES = 16;
  localparam int unsigned HDR_LEN = 4;
  localparam logic [7:0]  SYNC_BYTE   = 8'h5A;
  localparam logic [15:0] CRC_POLY    = 16'h8005;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] END_MARK    = 16'h0D0A;
  localparam logic [3:0]  ACK_CODE    = 4'hA;
  localparam logic [7:0]  NIBBLE_MASK = 8'h0F;

  // result queue in the back end
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SYNC = 2'd1,
    ST_BAD_CRC  = 2'd2,
    ST_BAD_END  = 2'd3
  } status_t;

  // one checked frame, handed from front to back
  typedef struct packed {
    status_t    status;
    logic       from_master;
    logic       retransmit;
    logic [7:0] type_code;
    logic [3:0] sender_counter;
    logic       ack_seen;
    logic       slot;
  } job_t;

  // one result item
  typedef struct packed {
    status_t    status;
    logic       from_master;
    logic       retransmit;
    logic [7:0] type_code;
    logic [3:0] sender_counter;
    logic       ack_seen;
    logic [7:0] payload_byte;
    logic [3:0] payload_index;
    logic       last;
  } result_t;

  // payload buffer slot handed back by the back end
  typedef struct packed {
    logic valid;
    logic slot;
  } release_t;

  // crc-16, msb first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/lfc_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module lfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lfc_job_fifo.sv =====
// two-entry queue of checked frames between front and back end
// depends on lfc_pkg
module lfc_job_fifo
  import lfc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== src/lfc_front.sv =====
// front end: takes frame bytes, runs the crc, buffers payload, checks the frame
// depends on lfc_pkg; writes the payload ram and pushes into the job queue
module lfc_front
  import lfc_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
  localparam int unsigned ADDR_W = $clog2(2 * PAYLOAD_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  output logic              full,
  output logic              job_push,
  output job_t              job,
  input  logic              job_full,
  input  release_t          rel,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata
);

  localparam int unsigned CRC_POS   = HDR_LEN + PAYLOAD_BYTES;
  localparam int unsigned FRAME_LEN = CRC_POS + 4;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);

  logic [POS_W-1:0] pos;
  logic [15:0]      crc;
  logic             sync_ok;
  logic [7:0]       hdr [3];
  logic [15:0]      rx_crc;
  logic [7:0]       end_low;
  logic             wr_slot;
  logic [1:0]       busy;

  logic             accept;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] pay_off;
  logic             in_payload;
  logic             final_byte;
  logic [15:0]      crc_in;
  logic [15:0]      endm;
  status_t          chk;

  // input accepted unless the write slot still drains or no job space is left
  assign full   = busy[wr_slot] || job_full;
  assign accept = push && !full;

  // position of this byte and checks on the final byte
  always_comb begin
    pos_eff    = frame_start ? '0 : pos;
    pay_off    = pos_eff - POS_W'(HDR_LEN);
    in_payload = (pos_eff >= POS_W'(HDR_LEN)) && (pos_eff < POS_W'(CRC_POS));
    final_byte = (pos_eff == POS_W'(FRAME_LEN - 1));
    crc_in     = (pos_eff == '0) ? CRC_INIT : crc;
    endm       = {rx_byte, end_low};
    if (!sync_ok) begin
      chk = ST_BAD_SYNC;
    end else if (rx_crc != crc) begin
      chk = ST_BAD_CRC;
    end else if (endm != END_MARK) begin
      chk = ST_BAD_END;
    end else begin
      chk = ST_OK;
    end
  end

  // payload write into the current slot
  assign ram_we    = accept && in_payload;
  assign ram_wdata = rx_byte;
  assign ram_waddr = wr_slot ? ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(pay_off) : ADDR_W'(pay_off);

  // job for a finished frame, header fields zero on error
  always_comb begin
    job_push = accept && final_byte;
    job      = '0;
    job.status = chk;
    job.slot   = wr_slot;
    if (chk == ST_OK) begin
      job.from_master    = hdr[0][7];
      job.retransmit     = hdr[0][6];
      job.type_code      = hdr[1];
      job.sender_counter = hdr[2][7:4];
      job.ack_seen       = ((hdr[2] & NIBBLE_MASK) == {4'h0, ACK_CODE});
    end
  end

  // position, crc and slot control
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      crc     <= CRC_INIT;
      sync_ok <= 1'b0;
      wr_slot <= 1'b0;
      busy    <= 2'b00;
    end else begin
      if (rel.valid) begin
        busy[rel.slot] <= 1'b0;
      end
      if (accept) begin
        if (pos_eff < POS_W'(CRC_POS)) begin
          crc <= crc16_byte(crc_in, rx_byte);
        end
        if (pos_eff == '0) begin
          sync_ok <= (rx_byte == SYNC_BYTE);
        end
        if (final_byte) begin
          pos <= '0;
          crc <= CRC_INIT;
          if (chk == ST_OK) begin
            busy[wr_slot] <= 1'b1;
            wr_slot       <= ~wr_slot;
          end
        end else begin
          pos <= pos_eff + POS_W'(1);
        end
      end
    end
  end

  // header, received crc and end mark bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr[0]  <= '0;
      hdr[1]  <= '0;
      hdr[2]  <= '0;
      rx_crc  <= '0;
      end_low <= '0;
    end else if (accept) begin
      if (pos_eff == POS_W'(1)) begin
        hdr[0] <= rx_byte;
      end
      if (pos_eff == POS_W'(2)) begin
        hdr[1] <= rx_byte;
      end
      if (pos_eff == POS_W'(3)) begin
        hdr[2] <= rx_byte;
      end
      if (pos_eff == POS_W'(CRC_POS)) begin
        rx_crc[7:0] <= rx_byte;
      end
      if (pos_eff == POS_W'(CRC_POS + 1)) begin
        rx_crc[15:8] <= rx_byte;
      end
      if (pos_eff == POS_W'(CRC_POS + 2)) begin
        end_low <= rx_byte;
      end
    end
  end

endmodule

// ===== src/lfc_back.sv =====
// back end: turns queued frames into result items, reading payload from the ram
// depends on lfc_pkg; feeds a small result queue that the receiver pops
module lfc_back
  import lfc_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
  localparam int unsigned ADDR_W = $clog2(2 * PAYLOAD_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_empty,
  input  job_t              job,
  output logic              job_pop,
  output release_t          rel,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  input  logic              pop,
  output logic              empty,
  output result_t           head
);

  localparam int unsigned IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  logic [IW-1:0]    idx;
  logic             iss_valid;
  result_t          iss;
  result_t          oq [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_head;
  logic [OQ_AW-1:0] oq_tail;
  logic [OQ_CW-1:0] oq_count;

  logic    can_issue;
  logic    issue;
  logic    is_err;
  logic    last_issue;
  logic    out_pop;
  result_t iss_next;
  result_t push_item;

  // issue one result when the queue has room for it and the one in flight
  assign can_issue  = (oq_count + OQ_CW'(iss_valid)) < OQ_CW'(OQ_DEPTH);
  assign issue      = can_issue && !job_empty;
  assign is_err     = (job.status != ST_OK);
  assign last_issue = is_err || (idx == IW'(PAYLOAD_BYTES - 1));
  assign job_pop    = issue && last_issue;
  assign rel.valid  = issue && last_issue && !is_err;
  assign rel.slot   = job.slot;
  assign ram_raddr  = job.slot ? ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(idx) : ADDR_W'(idx);

  assign empty   = (oq_count == '0);
  assign head    = oq[oq_head];
  assign out_pop = pop && !empty;

  // descriptor of the issued item, payload filled in from the registered ram read
  always_comb begin
    iss_next                = '0;
    iss_next.status         = job.status;
    iss_next.from_master    = job.from_master;
    iss_next.retransmit     = job.retransmit;
    iss_next.type_code      = job.type_code;
    iss_next.sender_counter = job.sender_counter;
    iss_next.ack_seen       = job.ack_seen;
    iss_next.payload_index  = is_err ? 4'h0 : 4'(idx);
    iss_next.last           = last_issue;
    push_item               = iss;
    if (iss.status == ST_OK) begin
      push_item.payload_byte = ram_rdata;
    end
  end

  // issue control and result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      iss_valid <= 1'b0;
      oq_head   <= '0;
      oq_tail   <= '0;
      oq_count  <= '0;
    end else begin
      iss_valid <= issue;
      if (issue) begin
        idx <= last_issue ? '0 : idx + IW'(1);
      end
      if (iss_valid) begin
        oq_tail <= oq_tail + OQ_AW'(1);
      end
      if (out_pop) begin
        oq_head <= oq_head + OQ_AW'(1);
      end
      if (iss_valid && !out_pop) begin
        oq_count <= oq_count + OQ_CW'(1);
      end else if (out_pop && !iss_valid) begin
        oq_count <= oq_count - OQ_CW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      iss <= iss_next;
    end
    if (iss_valid) begin
      oq[oq_tail] <= push_item;
    end
  end

endmodule

// ===== src/link_frame_checker_crc16_unit.sv =====
// Link frame checker with CRC-16 (poly 0x8005, init 0xFFFF, msb first).
// Input side is a queue: one frame byte per item, pushed with push while full
// is low; frame_start marks byte 0 and drops any partial frame. A frame is
// 4 header bytes, PAYLOAD_BYTES payload bytes, a little-endian crc and the
// end mark 0x0A 0x0D. Bytes are taken one per cycle while full is low.
// Output side is a queue: a result item waits on the ports while empty is low
// and leaves with pop. A good frame gives one item per payload byte, carrying
// the header fields; a failed check gives one item with the error status.
// The first item of a frame passes the frame queue, issue register and result
// queue; the payload then drains at one item per cycle while the result queue
// has room, from a double-buffered payload ram, one read port, so the drain overlaps the next frame's bytes.
// full rises while the next payload slot is still draining or the two-entry
// frame queue is full; a stalled receiver thus holds the input back only
// after one complete frame is buffered behind the one being drained.
// Reset clears position, crc, checks and all queues; no clearing pass.
// depends on lfc_pkg, lfc_front, lfc_job_fifo, lfc_back, lfc_ram
module link_frame_checker_crc16_unit
  import lfc_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status,
  output logic       from_master,
  output logic       retransmit,
  output logic [7:0] type_code,
  output logic [3:0] sender_counter,
  output logic       ack_seen,
  output logic [7:0] payload_byte,
  output logic [3:0] payload_index,
  output logic       last
);

  localparam int unsigned ADDR_W = $clog2(2 * PAYLOAD_BYTES);

  logic              job_push;
  job_t              job_in;
  logic              job_full;
  logic              job_pop;
  logic              job_empty;
  job_t              job_head;
  release_t          rel;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  result_t           res;

  lfc_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .rx_byte    (rx_byte),
    .frame_start(frame_start),
    .full       (full),
    .job_push   (job_push),
    .job        (job_in),
    .job_full   (job_full),
    .rel        (rel),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  lfc_job_fifo u_jobs (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .wdata(job_in),
    .full (job_full),
    .pop  (job_pop),
    .empty(job_empty),
    .head (job_head)
  );

  lfc_ram #(.WIDTH(8), .DEPTH(2 * PAYLOAD_BYTES)) u_payload_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lfc_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_empty(job_empty),
    .job      (job_head),
    .job_pop  (job_pop),
    .rel      (rel),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .pop      (pop),
    .empty    (empty),
    .head     (res)
  );

  // result fields
  assign status         = res.status;
  assign from_master    = res.from_master;
  assign retransmit     = res.retransmit;
  assign type_code      = res.type_code;
  assign sender_counter = res.sender_counter;
  assign ack_seen       = res.ack_seen;
  assign payload_byte   = res.payload_byte;
  assign payload_index  = res.payload_index;
  assign last           = res.last;

endmodule
